// ----- design/plst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants of the positional list store
// operation and status codes, field widths and the per-cell command bundle
// ----------------------------------------------------------------------------
package plst_pkg;

	localparam int MODE_W = 2;
	localparam int POS_W  = 7;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;
	localparam int LEN_W  = 7;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// widest cell index over the supported capacity range (up to 1024)
	localparam int CAPACITY_MAX = 1024;
	localparam int IDX_W        = $clog2(CAPACITY_MAX + 1);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// broadcast to every cell for one operation
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic [IDX_W-1:0] pos_idx;
		logic [IDX_W-1:0] cnt;
	} cell_cmd_t;

endpackage

// ----- design/plst_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plst_cell: one list entry
// holds a word, loads the new value, or takes the word of its lower or
// upper neighbor when the list opens or closes a gap
// ----------------------------------------------------------------------------
module plst_cell #(
	parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF,
	parameter int IDX        = 0
) (
	input  logic                      clk,
	input  plst_pkg::cell_cmd_t       cmd,
	input  logic [DATA_WIDTH-1:0]     value_in,
	input  logic [DATA_WIDTH-1:0]     lower_data,
	input  logic [DATA_WIDTH-1:0]     upper_data,
	output logic [DATA_WIDTH-1:0]     data_q,
	output logic [DATA_WIDTH-1:0]     rd_data
);
	import plst_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
	localparam logic [IDX_W-1:0] MY_IDX1 = IDX_W'(IDX + 1);

	logic hit;
	logic take_lower;
	logic take_upper;

	assign hit        = (MY_IDX == cmd.pos_idx);
	assign take_lower = cmd.ins && (MY_IDX > cmd.pos_idx) && (MY_IDX <= cmd.cnt);
	assign take_upper = cmd.del && (MY_IDX >= cmd.pos_idx) && (MY_IDX1 < cmd.cnt);

	always_ff @(posedge clk) begin
		if (cmd.ins && hit) begin
			data_q <= value_in;
		end else if (take_lower) begin
			data_q <= lower_data;
		end else if (take_upper) begin
			data_q <= upper_data;
		end
	end

	// gated onto the shared read bus only at the addressed place
	assign rd_data = (cmd.rd && hit) ? data_q : '0;

endmodule

// ----- design/positional_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of words addressed by 1-based position
// a row of entry cells that shift up on insert and down on delete
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start, busy            mode, position, value
//  result    done (one-cycle pulse) status, read_value, list_length
//
// one operation per cycle: a command transfers on start while busy is low,
// every cell moves in the same edge, and the result shows on the next cycle.
// the read path is an and-or over all cells, registered into read_value.
// busy stays low; the receiver cannot stall, so results never back up.
// reset clears the list count and the result strobe; entry words and result fields are not cleared.
// ----------------------------------------------------------------------------
module positional_list_store #(
	parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [plst_pkg::MODE_W-1:0] mode,
	input  logic [plst_pkg::POS_W-1:0]  position,
	input  logic [plst_pkg::WORD_W-1:0] value,
	output logic                        done,
	output logic [plst_pkg::STAT_W-1:0] status,
	output logic [plst_pkg::WORD_W-1:0] read_value,
	output logic [plst_pkg::LEN_W-1:0]  list_length
);
	import plst_pkg::*;

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_nxt;
	logic                  xfer;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	logic                  full;
	logic                  pos_zero;
	logic                  ins_ok;
	logic                  del_ok;
	logic                  rd_ok;
	logic [STAT_W-1:0]     stat_nxt;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] value_w;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [DATA_WIDTH-1:0] lower_w   [CAPACITY];
	logic [DATA_WIDTH-1:0] upper_w   [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_word;

	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [WORD_W-1:0] read_value_q;
	logic [LEN_W-1:0]  length_q;

	assign busy = 1'b0;
	assign xfer = start && !busy;

	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign full     = (cnt_q >= CAP_C);
	assign pos_zero = (position == '0);

	always_comb begin
		ins_ok = xfer && (mode == MODE_INSERT) && !full && !pos_zero
			&& (pos_c <= cnt_c + CMP_W'(1));
		del_ok = xfer && (mode == MODE_DELETE) && !pos_zero && (pos_c <= cnt_c);
		rd_ok  = xfer && (mode == MODE_READ) && !pos_zero && (pos_c <= cnt_c);
	end

	always_comb begin
		if ((mode == MODE_INSERT) && full) begin
			stat_nxt = ST_FULL;
		end else if (ins_ok || del_ok || rd_ok) begin
			stat_nxt = ST_OK;
		end else begin
			stat_nxt = ST_RANGE;
		end
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (ins_ok) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (del_ok) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end

	always_comb begin
		cmd.ins     = ins_ok;
		cmd.del     = del_ok;
		cmd.rd      = rd_ok;
		cmd.pos_idx = IDX_W'(position) - IDX_W'(1);
		cmd.cnt     = IDX_W'(cnt_q);
	end

	assign value_w = DATA_WIDTH'(value);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign lower_w[i] = '0;
			end else begin : g_mid_lo
				assign lower_w[i] = cell_data[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign upper_w[i] = '0;
			end else begin : g_mid_hi
				assign upper_w[i] = cell_data[i+1];
			end

			plst_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.IDX       (i)
			) u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.value_in  (value_w),
				.lower_data(lower_w[i]),
				.upper_data(upper_w[i]),
				.data_q    (cell_data[i]),
				.rd_data   (cell_rd[i])
			);
		end
	endgenerate

	// at most one cell drives a nonzero word
	always_comb begin
		rd_word = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_word = rd_word | cell_rd[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_nxt;
			done_q <= xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			status_q     <= stat_nxt;
			read_value_q <= WORD_W'(rd_word);
			length_q     <= LEN_W'(cnt_nxt);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign list_length = length_q;

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("list length above capacity");

	a_xfer_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted command produced no result");

	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (cnt_q == $past(cnt_q)))
		else $error("failed operation changed the list length");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> (list_length == LEN_W'(CAPACITY)))
		else $error("full status with list not at capacity");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (read_value == '0))
		else $error("read value nonzero on failed operation");
`endif

endmodule

// ----- tb/sv/tb_positional_list_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store: self-checking bench for the positional list store
// a directed table covers empty, bad-position, unused-mode and valid requests.
// random phases then grow, drain and churn the list, the sender idling except in two phases.
// every result is checked field by field against the table or a list model kept in step.
// ----------------------------------------------------------------------------
module tb_positional_list_store;
	import plst_pkg::*;

	localparam int LIST_CAP   = 64;
	localparam int RAND_ITEMS = 1500;
	localparam int PHASE_LEN  = 150;
	localparam int DIR_ROWS   = 22;
	localparam int DRAIN_CYC  = 4;
	localparam time TIMEOUT_NS = 2_000_000;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [WORD_W-1:0] rv;
		logic [LEN_W-1:0]  len;
	} list_result_t;

	typedef struct packed {
		logic [MODE_W-1:0] md;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] val;
		logic              typed;
		list_result_t      res;
	} op_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [MODE_W-1:0] mode;
	logic [POS_W-1:0]  position;
	logic [WORD_W-1:0] value;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [WORD_W-1:0] read_value;
	logic [LEN_W-1:0]  list_length;

	// list model
	logic [WORD_W-1:0] model_words [LIST_CAP];
	int unsigned       model_len;

	list_result_t pending_results [$];
	int unsigned  fail_count;

	// typed rows are obvious from the list contents; the rest use the model
	op_row_t dir_rows [DIR_ROWS] = '{
		'{MODE_READ,   7'd1,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd0}},
		'{MODE_DELETE, 7'd1,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd0}},
		'{MODE_INSERT, 7'd0,   32'h1234,     1'b1, '{ST_RANGE, 32'h0, 7'd0}},
		'{MODE_INSERT, 7'd2,   32'h1234,     1'b1, '{ST_RANGE, 32'h0, 7'd0}},
		'{MODE_INSERT, 7'd1,   32'hFFFFFFFF, 1'b1, '{ST_OK,    32'h0, 7'd1}},
		'{MODE_INSERT, 7'd1,   32'h00000000, 1'b1, '{ST_OK,    32'h0, 7'd2}},
		'{MODE_INSERT, 7'd3,   32'hA5A5A5A5, 1'b1, '{ST_OK,    32'h0, 7'd3}},
		'{MODE_INSERT, 7'd2,   32'h5A5A5A5A, 1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_READ,   7'd1,   32'hDEADBEEF, 1'b1, '{ST_OK,    32'h0, 7'd4}},
		'{MODE_READ,   7'd4,   32'h0,        1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_READ,   7'd3,   32'h0,        1'b1, '{ST_OK,    32'hFFFFFFFF, 7'd4}},
		'{MODE_UNUSED, 7'd1,   32'h77,       1'b1, '{ST_RANGE, 32'h0, 7'd4}},
		'{MODE_READ,   7'd127, 32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd4}},
		'{MODE_READ,   7'd5,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd4}},
		'{MODE_INSERT, 7'd6,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd4}},
		'{MODE_INSERT, 7'd5,   32'h80000001, 1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_DELETE, 7'd1,   32'h0,        1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_DELETE, 7'd4,   32'h0,        1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_DELETE, 7'd4,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd3}},
		'{MODE_READ,   7'd2,   32'h0,        1'b0, '{ST_OK,    32'h0, 7'd0}},
		'{MODE_READ,   7'd64,  32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd3}},
		'{MODE_DELETE, 7'd0,   32'h0,        1'b1, '{ST_RANGE, 32'h0, 7'd3}}
	};

	positional_list_store #(
		.CAPACITY   (LIST_CAP),
		.DATA_WIDTH (WORD_W)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.list_length (list_length)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one operation to the list model and return its result
	function automatic list_result_t list_apply(logic [MODE_W-1:0] md,
			logic [POS_W-1:0] pos, logic [WORD_W-1:0] val);
		list_result_t r;
		int unsigned  p;
		r = '{ST_OK, '0, '0};
		p = pos;
		case (md)
			MODE_INSERT: begin
				if (model_len >= LIST_CAP) begin
					r.st = ST_FULL;
				end else if (p == 0 || p > model_len + 1) begin
					r.st = ST_RANGE;
				end else begin
					for (int k = model_len; k > p - 1; k--)
						model_words[k] = model_words[k-1];
					model_words[p-1] = val;
					model_len++;
				end
			end
			MODE_DELETE: begin
				if (p == 0 || p > model_len) begin
					r.st = ST_RANGE;
				end else begin
					for (int k = p - 1; k + 1 < model_len; k++)
						model_words[k] = model_words[k+1];
					model_len--;
				end
			end
			MODE_READ: begin
				if (p == 0 || p > model_len)
					r.st = ST_RANGE;
				else
					r.rv = model_words[p-1];
			end
			default: begin
				r.st = ST_RANGE;
			end
		endcase
		r.len = model_len[LEN_W-1:0];
		return r;
	endfunction

	// drive one command and wait for its transfer; hold start across items
	task automatic send_op(logic [MODE_W-1:0] md, logic [POS_W-1:0] pos,
			logic [WORD_W-1:0] val, bit idle_on, bit typed, list_result_t typed_res);
		list_result_t r;
		while (idle_on && $urandom_range(99) < 35) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start    <= 1'b1;
		mode     <= md;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = list_apply(md, pos, val);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result st=%0d rv=%h len=%0d", $time,
					status, read_value, list_length);
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					fail_count++;
					$display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
				end
				if (read_value !== exp_r.rv) begin
					fail_count++;
					$display("%0t: read_value expected %h actual %h", $time, exp_r.rv,
						read_value);
				end
				if (list_length !== exp_r.len) begin
					fail_count++;
					$display("%0t: list_length expected %0d actual %0d", $time, exp_r.len,
						list_length);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb_positional_list_store: done, errors");
		$finish;
	end

	initial begin
		logic [MODE_W-1:0] md;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] val;
		int unsigned       phase;
		int unsigned       roll;
		int unsigned       ins_pct;
		int unsigned       del_pct;
		int unsigned       hi;
		bit                idle_on;

		fail_count = 0;
		model_len  = 0;
		for (int k = 0; k < LIST_CAP; k++)
			model_words[k] = '0;
		arst_n   = 1'b0;
		start    = 1'b0;
		mode     = MODE_INSERT;
		position = '0;
		value    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send_op(dir_rows[i].md, dir_rows[i].pos, dir_rows[i].val, 1'b1,
				dir_rows[i].typed, dir_rows[i].res);
		wait_drained();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			phase = n / PHASE_LEN;
			// sender holds off until the list store has answered everything
			if (n != 0 && n % PHASE_LEN == 0 && phase % 3 == 0)
				wait_drained();
			// grow, drain, churn; two phases in the middle run without gaps
			case (phase % 3)
				0: begin ins_pct = 75; del_pct = 10; end
				1: begin ins_pct = 15; del_pct = 65; end
				default: begin ins_pct = 40; del_pct = 30; end
			endcase
			idle_on = !(phase == 4 || phase == 5);

			roll = $urandom_range(99);
			if (roll < 3)
				md = MODE_UNUSED;
			else if (roll < ins_pct)
				md = MODE_INSERT;
			else if (roll < ins_pct + del_pct)
				md = MODE_DELETE;
			else
				md = MODE_READ;

			hi = (md == MODE_INSERT) ? model_len + 1 : model_len;
			roll = $urandom_range(99);
			if (roll < 12 || hi == 0)
				pos = POS_W'($urandom_range(127));
			else if (roll < 20)
				pos = hi[POS_W-1:0];
			else if (roll < 26)
				pos = 7'd1;
			else
				pos = POS_W'($urandom_range(hi, 1));

			roll = $urandom_range(99);
			if (roll < 4)
				val = '0;
			else if (roll < 8)
				val = '1;
			else
				val = $urandom;

			send_op(md, pos, val, idle_on, 1'b0, '0);
		end

		wait_drained();
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("tb_positional_list_store: done, clean");
		else
			$display("tb_positional_list_store: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/plst_pkg.sv
design/plst_cell.sv
design/positional_list_store.sv
tb/sv/tb_positional_list_store.sv
